@@ rtl/lru_cache_tag_model_defines.svh @@
// Assertion macros used by the checker file.
`ifndef LRU_CACHE_TAG_MODEL_DEFINES_SVH
`define LRU_CACHE_TAG_MODEL_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LCM_ASSERT_NOW(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lcm assertion failed");

// Next-cycle implication, disabled during reset.
`define LCM_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lcm assertion failed");

`endif

@@ rtl/lcm_pkg.sv @@
// ----------------------------------------------------------------------------
// lcm_pkg
// Types and constants shared by the cache tag model modules.
// ----------------------------------------------------------------------------
package lcm_pkg;

    localparam int ADDR_BITS = 31;
    localparam int TAG_W     = ADDR_BITS - 2;
    localparam int RANK_W    = 10;
    localparam int SET_W     = 10;
    localparam int CNT_W     = 32;

    // Configuration register indexes
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd0;
    localparam logic [1:0] CFG_LINES_LOG2  = 2'd1;
    localparam logic [1:0] CFG_WAYS_LOG2   = 2'd2;

    typedef struct packed {
        logic                 is_write;
        logic [ADDR_BITS-1:0] address;
    } lcm_cmd_t;

    typedef struct packed {
        logic             hit;
        logic             dirty_eviction;
        logic [SET_W-1:0] set_index;
        logic [CNT_W-1:0] read_total;
        logic [CNT_W-1:0] write_total;
        logic [CNT_W-1:0] read_miss_total;
        logic [CNT_W-1:0] write_miss_total;
        logic [CNT_W-1:0] dirty_evict_total;
    } lcm_result_t;

    typedef struct packed {
        logic              valid;
        logic              dirty;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] rank;
    } lcm_entry_t;

    typedef struct packed {
        logic clearing;
        logic idle;
    } lcm_status_t;

endpackage

@@ rtl/lcm_front.sv @@
// ----------------------------------------------------------------------------
// lcm_front
// Holds the configuration registers and splits an access into set and tag.
// ----------------------------------------------------------------------------
module lcm_front
    import lcm_pkg::*;
#(
    parameter int MAX_LINES = 1024,
    parameter int IDX_W     = 10,
    parameter int ITEM_W    = 1 + TAG_W + 2 * IDX_W + SET_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  logic [1:0]        cfg_index,
    input  logic [3:0]        cfg_data,
    output logic              clr_req,
    input  lcm_cmd_t          cmd,
    output logic [ITEM_W-1:0] item
);

    localparam int MAX_LG = $clog2(MAX_LINES + 1) - 1;

    logic [3:0] offset_bits_reg;
    logic [3:0] lines_log2_reg;
    logic [3:0] ways_log2_reg;

    logic [3:0]           off;
    logic [3:0]           lg;
    logic [3:0]           wl;
    logic [3:0]           sl;
    logic [4:0]           tag_shift;
    logic [ADDR_BITS-1:0] set_full;
    logic [ADDR_BITS-1:0] tag_full;
    logic [IDX_W-1:0]     base;
    logic [IDX_W-1:0]     last_way;

    // Configuration writes; any known index flushes the cache
    assign clr_req = cfg_valid && (cfg_index == CFG_OFFSET_BITS ||
                     cfg_index == CFG_LINES_LOG2 || cfg_index == CFG_WAYS_LOG2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_bits_reg <= 4'd6;
            lines_log2_reg  <= 4'd10;
            ways_log2_reg   <= 4'd2;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OFFSET_BITS: offset_bits_reg <= cfg_data;
                CFG_LINES_LOG2:  lines_log2_reg  <= cfg_data;
                CFG_WAYS_LOG2:   ways_log2_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the geometry and split the address
    always_comb
    begin
        off = offset_bits_reg;
        if (off < 4'd2)  off = 4'd2;
        if (off > 4'd12) off = 4'd12;
        lg = ({1'b0, lines_log2_reg} > 5'(MAX_LG)) ? 4'(MAX_LG) : lines_log2_reg;
        wl = (ways_log2_reg > lg) ? lg : ways_log2_reg;
        sl = lg - wl;
        tag_shift = {1'b0, off} + {1'b0, sl};
        set_full = (cmd.address >> off) & ~({ADDR_BITS{1'b1}} << sl);
        tag_full = cmd.address >> tag_shift;
        base     = IDX_W'(set_full) << wl;
        last_way = ~({IDX_W{1'b1}} << wl);
    end

    assign item = {cmd.is_write, TAG_W'(tag_full), base, last_way, SET_W'(set_full)};

endmodule

@@ rtl/lcm_queue.sv @@
// ----------------------------------------------------------------------------
// lcm_queue
// Two-entry queue between the decode front and the tag walk back end.
// ----------------------------------------------------------------------------
module lcm_queue #(
    parameter int WIDTH = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty,
    output logic             full
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign empty = (count_reg == 2'd0);
    assign full  = (count_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                slot_reg[wr_ptr_reg] <= push_data;
                wr_ptr_reg           <= ~wr_ptr_reg;
            end
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/lcm_back.sv @@
// ----------------------------------------------------------------------------
// lcm_back
// Walks the ways of one set in the line memory: a scan pass finds hit,
// free way and LRU victim, an update pass rewrites ranks and the target.
// ----------------------------------------------------------------------------
module lcm_back
    import lcm_pkg::*;
#(
    parameter int MAX_LINES = 1024,
    parameter int IDX_W     = 10,
    parameter int ITEM_W    = 1 + TAG_W + 2 * IDX_W + SET_W
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              clr_req,
    input  logic [ITEM_W-1:0] item,
    input  logic              q_empty,
    output logic              pop,
    output lcm_status_t       status,
    output logic              done,
    output lcm_result_t       result
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN_RD, S_SCAN_EV, S_DECIDE, S_UPD_RD, S_UPD_WR
    } state_t;

    state_t state_reg;

    lcm_entry_t mem [MAX_LINES];
    lcm_entry_t rdata_reg;

    logic             wr_reg;
    logic [TAG_W-1:0] tag_reg;
    logic [IDX_W-1:0] base_reg;
    logic [IDX_W-1:0] last_reg;
    logic [SET_W-1:0] set_reg;
    logic [IDX_W-1:0] w_reg;
    logic [IDX_W-1:0] clr_reg;

    logic              hit_reg;
    logic [IDX_W-1:0]  hit_idx_reg;
    logic [RANK_W-1:0] hit_rank_reg;
    logic              free_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic [RANK_W-1:0] best_rank_reg;
    logic [IDX_W-1:0]  best_idx_reg;
    logic              best_dirty_reg;
    logic [IDX_W-1:0]  target_reg;
    logic              dev_reg;
    logic              done_reg;

    logic [CNT_W-1:0] rd_cnt_reg;
    logic [CNT_W-1:0] wr_cnt_reg;
    logic [CNT_W-1:0] rd_miss_reg;
    logic [CNT_W-1:0] wr_miss_reg;
    logic [CNT_W-1:0] dev_cnt_reg;

    logic             i_wr;
    logic [TAG_W-1:0] i_tag;
    logic [IDX_W-1:0] i_base;
    logic [IDX_W-1:0] i_last;
    logic [SET_W-1:0] i_set;

    logic [IDX_W-1:0] cur_idx;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    lcm_entry_t       mem_wdata;
    lcm_entry_t       upd_entry;

    assign {i_wr, i_tag, i_base, i_last, i_set} = item;
    assign cur_idx = base_reg + w_reg;
    assign pop     = (state_reg == S_IDLE) && !q_empty && !clr_req;

    assign status.clearing = (state_reg == S_CLEAR);
    assign status.idle     = (state_reg == S_IDLE);

    // New contents of the way being updated
    always_comb
    begin
        upd_entry = rdata_reg;
        if (cur_idx == target_reg)
        begin
            upd_entry.valid = 1'b1;
            upd_entry.rank  = '0;
            if (hit_reg)
                upd_entry.dirty = rdata_reg.dirty | wr_reg;
            else
            begin
                upd_entry.dirty = wr_reg;
                upd_entry.tag   = tag_reg;
            end
        end
        else if (hit_reg)
        begin
            if (rdata_reg.valid && rdata_reg.rank < hit_rank_reg)
                upd_entry.rank = rdata_reg.rank + 1'b1;
        end
        else if (rdata_reg.valid && rdata_reg.rank != {RANK_W{1'b1}})
            upd_entry.rank = rdata_reg.rank + 1'b1;
    end

    // Memory write port select
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cur_idx;
        mem_wdata = upd_entry;
        if (state_reg == S_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (state_reg == S_UPD_WR)
            mem_we = 1'b1;
    end

    // Line memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[cur_idx];
    end

    // Sequencer, scan tracking and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            done_reg       <= 1'b0;
            wr_reg         <= 1'b0;
            tag_reg        <= '0;
            base_reg       <= '0;
            last_reg       <= '0;
            set_reg        <= '0;
            w_reg          <= '0;
            hit_reg        <= 1'b0;
            hit_idx_reg    <= '0;
            hit_rank_reg   <= '0;
            free_reg       <= 1'b0;
            free_idx_reg   <= '0;
            best_rank_reg  <= '0;
            best_idx_reg   <= '0;
            best_dirty_reg <= 1'b0;
            target_reg     <= '0;
            dev_reg        <= 1'b0;
            rd_cnt_reg     <= '0;
            wr_cnt_reg     <= '0;
            rd_miss_reg    <= '0;
            wr_miss_reg    <= '0;
            dev_cnt_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (clr_req)
            begin
                state_reg <= S_CLEAR;
                clr_reg   <= '0;
            end
            else
            begin
                unique case (state_reg)
                    S_CLEAR:
                    begin
                        clr_reg <= clr_reg + 1'b1;
                        if (clr_reg == IDX_W'(MAX_LINES - 1))
                            state_reg <= S_IDLE;
                    end
                    S_IDLE:
                    begin
                        if (!q_empty)
                        begin
                            wr_reg         <= i_wr;
                            tag_reg        <= i_tag;
                            base_reg       <= i_base;
                            last_reg       <= i_last;
                            set_reg        <= i_set;
                            w_reg          <= '0;
                            hit_reg        <= 1'b0;
                            free_reg       <= 1'b0;
                            best_rank_reg  <= '0;
                            best_idx_reg   <= i_base;
                            best_dirty_reg <= 1'b0;
                            state_reg      <= S_SCAN_RD;
                        end
                    end
                    S_SCAN_RD:
                        state_reg <= S_SCAN_EV;
                    S_SCAN_EV:
                    begin
                        if (!hit_reg && rdata_reg.valid && rdata_reg.tag == tag_reg)
                        begin
                            hit_reg      <= 1'b1;
                            hit_idx_reg  <= cur_idx;
                            hit_rank_reg <= rdata_reg.rank;
                        end
                        if (!free_reg && !rdata_reg.valid)
                        begin
                            free_reg     <= 1'b1;
                            free_idx_reg <= cur_idx;
                        end
                        if (rdata_reg.rank >= best_rank_reg)
                        begin
                            best_rank_reg  <= rdata_reg.rank;
                            best_idx_reg   <= cur_idx;
                            best_dirty_reg <= rdata_reg.dirty;
                        end
                        w_reg     <= w_reg + 1'b1;
                        state_reg <= (w_reg == last_reg) ? S_DECIDE : S_SCAN_RD;
                    end
                    S_DECIDE:
                    begin
                        w_reg <= '0;
                        dev_reg <= !hit_reg && !free_reg && best_dirty_reg;
                        target_reg <= hit_reg ? hit_idx_reg :
                                      (free_reg ? free_idx_reg : best_idx_reg);
                        if (wr_reg)
                        begin
                            if (wr_cnt_reg != '1) wr_cnt_reg <= wr_cnt_reg + 1'b1;
                            if (!hit_reg && wr_miss_reg != '1)
                                wr_miss_reg <= wr_miss_reg + 1'b1;
                        end
                        else
                        begin
                            if (rd_cnt_reg != '1) rd_cnt_reg <= rd_cnt_reg + 1'b1;
                            if (!hit_reg && rd_miss_reg != '1)
                                rd_miss_reg <= rd_miss_reg + 1'b1;
                        end
                        if (!hit_reg && !free_reg && best_dirty_reg && dev_cnt_reg != '1)
                            dev_cnt_reg <= dev_cnt_reg + 1'b1;
                        state_reg <= S_UPD_RD;
                    end
                    S_UPD_RD:
                        state_reg <= S_UPD_WR;
                    S_UPD_WR:
                    begin
                        w_reg <= w_reg + 1'b1;
                        if (w_reg == last_reg)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_UPD_RD;
                    end
                    default:
                        state_reg <= S_IDLE;
                endcase
            end
        end
    end

    assign done                     = done_reg;
    assign result.hit               = hit_reg;
    assign result.dirty_eviction    = dev_reg;
    assign result.set_index         = set_reg;
    assign result.read_total        = rd_cnt_reg;
    assign result.write_total       = wr_cnt_reg;
    assign result.read_miss_total   = rd_miss_reg;
    assign result.write_miss_total  = wr_miss_reg;
    assign result.dirty_evict_total = dev_cnt_reg;

endmodule

@@ rtl/lru_cache_tag_model.sv @@
// ----------------------------------------------------------------------------
// lru_cache_tag_model
// Set-associative write-back LRU cache tag model with access counters.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an access transaction (cmd) is taken on a clock edge with
//   start high and busy low. The front decodes set and tag into a two-entry
//   queue; busy is high while that queue is full or the line memory is being
//   cleared.
//   Result channel: done is high for exactly one cycle with result valid.
//   The receiver cannot stall; results come out in access order.
//   Configuration: cfg_valid/cfg_ready, cfg_ready is always high. A write of
//   a known register flushes all lines (counters kept).
//   Timing: the back end handles one access at a time and walks each way
//   (ways = 2^ways_log2 after clamping) twice through the line memory, a
//   scan visit (read, evaluate) and an update visit (read, write); the
//   two-entry queue keeps taking accesses while it is not full. The default
//   geometry is 4-way.
//   Reset and every write of a known register start a clearing pass over all
//   MAX_LINES lines, one line a cycle, during which busy is high.
// ----------------------------------------------------------------------------
module lru_cache_tag_model
    import lcm_pkg::*;
#(
    parameter int MAX_LINES = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  lcm_cmd_t    cmd,
    output logic        done,
    output lcm_result_t result,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

    localparam int IDX_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int ITEM_W = 1 + TAG_W + 2 * IDX_W + SET_W;

    logic              clr_req;
    logic [ITEM_W-1:0] item_in;
    logic [ITEM_W-1:0] item_head;
    logic              q_empty;
    logic              q_full;
    logic              pop;
    logic              accept;
    lcm_status_t       status;

    assign cfg_ready = 1'b1;
    assign busy      = q_full || status.clearing;
    assign accept    = start && !busy;

    lcm_front #(.MAX_LINES(MAX_LINES), .IDX_W(IDX_W), .ITEM_W(ITEM_W)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clr_req   (clr_req),
        .cmd       (cmd),
        .item      (item_in)
    );

    lcm_queue #(.WIDTH(ITEM_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (item_in),
        .pop       (pop),
        .head      (item_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    lcm_back #(.MAX_LINES(MAX_LINES), .IDX_W(IDX_W), .ITEM_W(ITEM_W)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .clr_req (clr_req),
        .item    (item_head),
        .q_empty (q_empty),
        .pop     (pop),
        .status  (status),
        .done    (done),
        .result  (result)
    );

endmodule

@@ rtl/lcm_checker.sv @@
// ----------------------------------------------------------------------------
// lcm_checker
// Port-level checks of the cache tag model, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_cache_tag_model_defines.svh"

module lcm_checker
    import lcm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input lcm_result_t result
);

    // A hit never evicts
    `LCM_ASSERT_NOW(a_hit_no_evict, done && result.hit, !result.dirty_eviction)

    // Read miss count never passes the read count
    `LCM_ASSERT_NOW(a_miss_le_reads, done, result.read_miss_total <= result.read_total)

    // Dirty evictions never pass all misses of either kind; sum kept one bit wider
    `LCM_ASSERT_NOW(a_dev_le_miss, done,
        {1'b0, result.dirty_evict_total} <=
        {1'b0, result.read_miss_total} + {1'b0, result.write_miss_total})

    // Result strobe lasts one cycle
    `LCM_ASSERT_NEXT(a_done_pulse, done, !done)

endmodule

bind lru_cache_tag_model lcm_checker u_lcm_checker (.*);
